// ----- rtl/periodic_value_noise_fbm_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the periodic value noise fractal sum block
// Shared property templates clocked on clk_i, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_VALUE_NOISE_FBM_DEFINES_SVH
`define PERIODIC_VALUE_NOISE_FBM_DEFINES_SVH

// same-cycle implication
`define PVNF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pvnf: property violated");

// next-cycle implication
`define PVNF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pvnf: property violated");

`endif

// ----- rtl/pvnf_pkg.sv -----
// ----------------------------------------------------------------------------
// pvnf_pkg
// Types, widths, hash constants and amplitude tables for the noise pipeline.
// ----------------------------------------------------------------------------
package pvnf_pkg;

  localparam int COORD_W  = 28;
  localparam int PERIOD_W = 13;
  localparam int SEED_W   = 32;
  localparam int OCT_W    = 4;
  localparam int VAL_W    = 16;
  localparam int FRAC_W   = 24;
  localparam int HASH_W   = 32;
  localparam int SAMP_W   = 25;
  localparam int AMP_W    = 24;
  localparam int PROD_W   = SAMP_W + AMP_W;
  localparam int NORM_W   = 25;
  localparam int DEN_W    = NORM_W + 8;
  localparam int SUM_W    = 50;
  localparam int QUO_W    = 17;
  localparam int LANE_LAT = 9;
  localparam int DIV_LAT  = QUO_W + 2;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam int DEF_MAX_OCTAVES     = 8;
  localparam int DEF_COORD_FRAC_BITS = 16;

  localparam logic [HASH_W-1:0] HASH_CX   = 32'd374761393;
  localparam logic [HASH_W-1:0] HASH_CY   = 32'd668265263;
  localparam logic [HASH_W-1:0] HASH_SEED = 32'd2246822519;
  localparam logic [HASH_W-1:0] HASH_MIX  = 32'd1274126177;

  localparam int SEED_STEP_PLAIN  = 137;
  localparam int SEED_STEP_BILLOW = 173;

  localparam logic [PERIOD_W-1:0] RST_BASE_PERIOD  = 13'd8;
  localparam logic [SEED_W-1:0]   RST_NOISE_SEED   = '0;
  localparam logic [OCT_W-1:0]    RST_OCTAVE_COUNT = 4'd3;
  localparam logic                RST_BILLOW_MODE  = 1'b0;

  typedef enum logic [1:0] {
    REG_BASE_PERIOD  = 2'd0,
    REG_NOISE_SEED   = 2'd1,
    REG_OCTAVE_COUNT = 2'd2,
    REG_BILLOW_MODE  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [PERIOD_W-1:0] base_period;
    logic [SEED_W-1:0]   noise_seed;
    logic [OCT_W-1:0]    octave_count;
    logic                billow_mode;
  } cfg_t;

  // Q0.24 amplitude of octave k
  function automatic logic [AMP_W-1:0] octave_amp(input int k, input logic billow);
    longint amp;
    amp = longint'(1) << 23;
    for (int i = 0; i < k; i++) begin
      if (billow) begin
        amp = (amp * 26 + 25) / 50;
      end else begin
        amp = amp >> 1;
      end
    end
    return AMP_W'(amp);
  endfunction

  // sum of the first n amplitudes
  function automatic logic [NORM_W-1:0] octave_norm(input int n, input logic billow);
    longint acc;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      acc = acc + longint'(octave_amp(i, billow));
    end
    return NORM_W'(acc);
  endfunction

endpackage

// ----- rtl/pvnf_regs.sv -----
// ----------------------------------------------------------------------------
// pvnf_regs
// APB register file holding period, seed, octave count and billow mode.
// ----------------------------------------------------------------------------
module pvnf_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pvnf_pkg::ADDR_W-1:0]  paddr,
  input  logic [pvnf_pkg::DATA_W-1:0]  pwdata,
  output logic [pvnf_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output pvnf_pkg::cfg_t               cfg_o
);
  import pvnf_pkg::*;

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_BASE_PERIOD:  cfg_d.base_period  = pwdata[PERIOD_W-1:0];
        REG_NOISE_SEED:   cfg_d.noise_seed   = pwdata[SEED_W-1:0];
        REG_OCTAVE_COUNT: cfg_d.octave_count = pwdata[OCT_W-1:0];
        REG_BILLOW_MODE:  cfg_d.billow_mode  = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_period  <= RST_BASE_PERIOD;
      cfg_q.noise_seed   <= RST_NOISE_SEED;
      cfg_q.octave_count <= RST_OCTAVE_COUNT;
      cfg_q.billow_mode  <= RST_BILLOW_MODE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_BASE_PERIOD:  prdata = DATA_W'(cfg_q.base_period);
      REG_NOISE_SEED:   prdata = DATA_W'(cfg_q.noise_seed);
      REG_OCTAVE_COUNT: prdata = DATA_W'(cfg_q.octave_count);
      REG_BILLOW_MODE:  prdata = DATA_W'(cfg_q.billow_mode);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/pvnf_wrap.sv -----
// ----------------------------------------------------------------------------
// pvnf_wrap
// Pipelined remainder of x by (period << frac bits), one quotient bit a stage.
// ----------------------------------------------------------------------------
module pvnf_wrap #(
  parameter int COORD_FRAC_BITS = pvnf_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  input  logic signed [pvnf_pkg::COORD_W-1:0]           x_i,
  input  logic signed [pvnf_pkg::COORD_W-1:0]           y_i,
  input  logic [pvnf_pkg::PERIOD_W-1:0]                 base_period_i,
  output logic                                          valid_o,
  output logic [pvnf_pkg::PERIOD_W+COORD_FRAC_BITS-1:0] rem_o,
  output logic signed [pvnf_pkg::COORD_W-1:0]           y_o
);
  import pvnf_pkg::*;

  localparam int F  = COORD_FRAC_BITS;
  localparam int DW = PERIOD_W + F;
  localparam int NQ = COORD_W - F;
  localparam int CW = DW + NQ;

  logic [PERIOD_W-1:0] per_eff;
  logic [DW-1:0]       dvs;

  logic [COORD_W-1:0]        rem_q [NQ+1];
  logic                      neg_q [NQ+1];
  logic signed [COORD_W-1:0] y_q   [NQ+1];
  logic [NQ:0]               v_q;

  logic [DW-1:0]             rem_fix;
  logic [DW-1:0]             out_q;
  logic signed [COORD_W-1:0] yo_q;
  logic                      vo_q;

  assign per_eff = (base_period_i == '0) ? PERIOD_W'(1) : base_period_i;
  assign dvs     = DW'(per_eff) << F;

  always_ff @(posedge clk_i) begin
    rem_q[0] <= x_i[COORD_W-1] ? COORD_W'(-x_i) : COORD_W'(x_i);
    neg_q[0] <= x_i[COORD_W-1];
    y_q[0]   <= y_i;
  end

  for (genvar i = 0; i < NQ; i++) begin : g_step
    localparam int J = NQ - 1 - i;
    logic [CW-1:0] sub_w, rem_w;
    assign sub_w = CW'(dvs) << J;
    assign rem_w = CW'(rem_q[i]);
    always_ff @(posedge clk_i) begin
      rem_q[i+1] <= (rem_w >= sub_w) ? COORD_W'(rem_w - sub_w) : rem_q[i];
      neg_q[i+1] <= neg_q[i];
      y_q[i+1]   <= y_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vo_q <= 1'b0;
    end else begin
      v_q  <= {v_q[NQ-1:0], valid_i};
      vo_q <= v_q[NQ];
    end
  end

  assign rem_fix = (neg_q[NQ] && (rem_q[NQ] != '0)) ? (dvs - DW'(rem_q[NQ]))
                                                     : DW'(rem_q[NQ]);

  always_ff @(posedge clk_i) begin
    out_q <= rem_fix;
    yo_q  <= y_q[NQ];
  end

  assign valid_o = vo_q;
  assign rem_o   = out_q;
  assign y_o     = yo_q;

endmodule

// ----- rtl/pvnf_octave.sv -----
// ----------------------------------------------------------------------------
// pvnf_octave
// One octave lane: lattice corners, hash, smoothstep, bilerp, fold, weight.
// ----------------------------------------------------------------------------
module pvnf_octave #(
  parameter int K               = 0,
  parameter int COORD_FRAC_BITS = pvnf_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  input  logic [pvnf_pkg::PERIOD_W+COORD_FRAC_BITS-1:0] rem_i,
  input  logic signed [pvnf_pkg::COORD_W-1:0]           y_i,
  input  pvnf_pkg::cfg_t                                cfg_i,
  input  logic                                          enable_i,
  output logic                                          valid_o,
  output logic [pvnf_pkg::PROD_W-1:0]                   prod_o
);
  import pvnf_pkg::*;

  localparam int F   = COORD_FRAC_BITS;
  localparam int DW  = PERIOD_W + F;
  localparam int SXW = DW + K;
  localparam int SYW = COORD_W + K;
  localparam logic [HASH_W-1:0] OFS_P = HASH_W'(K * SEED_STEP_PLAIN);
  localparam logic [HASH_W-1:0] OFS_B = HASH_W'(K * SEED_STEP_BILLOW);
  localparam logic [AMP_W-1:0]  AMP_P = octave_amp(K, 1'b0);
  localparam logic [AMP_W-1:0]  AMP_B = octave_amp(K, 1'b1);
  localparam logic [25:0]       THREE = 26'(3 * (1 << FRAC_W));
  localparam logic [SAMP_W-1:0] ONE   = SAMP_W'(1 << FRAC_W);

  logic [LANE_LAT-1:0] v_q;

  // stage 1: cells and fractions
  logic [SXW-1:0]        sx;
  logic signed [SYW-1:0] sy;
  logic [HASH_W-1:0]     x0_w, x0p1_w, period_w;
  logic [F-1:0]          fx_w, fy_w;
  logic [HASH_W-1:0]     x0_q, x1_q, cy_q;
  logic [FRAC_W-1:0]     tx_q, ty_q;

  assign sx       = SXW'(rem_i) << K;
  assign sy       = SYW'(y_i) <<< K;
  assign x0_w     = HASH_W'(sx >> F);
  assign x0p1_w   = x0_w + HASH_W'(1);
  assign period_w = HASH_W'(cfg_i.base_period) << K;
  assign fx_w     = sx[F-1:0];
  assign fy_w     = sy[F-1:0];

  always_ff @(posedge clk_i) begin
    if (cfg_i.base_period == '0) begin
      x0_q <= '0;
      x1_q <= '0;
    end else begin
      x0_q <= x0_w;
      x1_q <= (x0p1_w == period_w) ? '0 : x0p1_w;
    end
    cy_q <= HASH_W'(sy >>> F);
    tx_q <= FRAC_W'(fx_w) << (FRAC_W - F);
    ty_q <= FRAC_W'(fy_w) << (FRAC_W - F);
  end

  // stage 2: corner products, seed term, t squared
  logic [HASH_W-1:0] mx0_q, mx1_q, my0_q, my1_q, sd_q;
  logic [FRAC_W-1:0] tx2_q, ty2_q, tx1_q, ty1_q;

  always_ff @(posedge clk_i) begin
    mx0_q <= x0_q * HASH_CX;
    mx1_q <= x1_q * HASH_CX;
    my0_q <= cy_q * HASH_CY;
    my1_q <= (cy_q + HASH_W'(1)) * HASH_CY;
    sd_q  <= (cfg_i.noise_seed + (cfg_i.billow_mode ? OFS_B : OFS_P)) * HASH_SEED;
    tx2_q <= FRAC_W'((48'(tx_q) * 48'(tx_q)) >> FRAC_W);
    ty2_q <= FRAC_W'((48'(ty_q) * 48'(ty_q)) >> FRAC_W);
    tx1_q <= tx_q;
    ty1_q <= ty_q;
  end

  // stage 3: hash sum and first mix, smoothstep weights
  logic [HASH_W-1:0] hs [4];
  logic [HASH_W-1:0] g_q [4];
  logic [25:0]       kx, ky;
  logic [FRAC_W-1:0] wx3_q, wy3_q;

  assign hs[0] = mx0_q + my0_q + sd_q;
  assign hs[1] = mx1_q + my0_q + sd_q;
  assign hs[2] = mx0_q + my1_q + sd_q;
  assign hs[3] = mx1_q + my1_q + sd_q;
  assign kx    = THREE - (26'(tx1_q) << 1);
  assign ky    = THREE - (26'(ty1_q) << 1);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      g_q[i] <= hs[i] ^ (hs[i] >> 13);
    end
    wx3_q <= FRAC_W'((50'(tx2_q) * 50'(kx)) >> FRAC_W);
    wy3_q <= FRAC_W'((50'(ty2_q) * 50'(ky)) >> FRAC_W);
  end

  // stage 4: second mix multiply
  logic [HASH_W-1:0] m_q [4];
  logic [FRAC_W-1:0] wx4_q, wy4_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      m_q[i] <= g_q[i] * HASH_MIX;
    end
    wx4_q <= wx3_q;
    wy4_q <= wy3_q;
  end

  // stage 5: corner values, horizontal lerp products
  logic [HASH_W-1:0]   hm [4];
  logic [FRAC_W-1:0]   hv [4];
  logic signed [24:0]  dab, dcd;
  logic signed [49:0]  pa_q, pc_q;
  logic [FRAC_W-1:0]   a5_q, c5_q, wy5_q;

  for (genvar i = 0; i < 4; i++) begin : g_corner
    assign hm[i] = m_q[i] ^ (m_q[i] >> 16);
    assign hv[i] = hm[i][FRAC_W-1:0];
  end

  assign dab = $signed({1'b0, hv[1]}) - $signed({1'b0, hv[0]});
  assign dcd = $signed({1'b0, hv[3]}) - $signed({1'b0, hv[2]});

  always_ff @(posedge clk_i) begin
    pa_q  <= dab * $signed({1'b0, wx4_q});
    pc_q  <= dcd * $signed({1'b0, wx4_q});
    a5_q  <= hv[0];
    c5_q  <= hv[2];
    wy5_q <= wy4_q;
  end

  // stage 6: horizontal lerp results
  logic signed [25:0] h0_w, h1_w;
  logic [FRAC_W-1:0]  h0_q, h1_q, wy6_q;

  assign h0_w = $signed({2'b00, a5_q}) + 26'(pa_q >>> FRAC_W);
  assign h1_w = $signed({2'b00, c5_q}) + 26'(pc_q >>> FRAC_W);

  always_ff @(posedge clk_i) begin
    h0_q  <= h0_w[FRAC_W-1:0];
    h1_q  <= h1_w[FRAC_W-1:0];
    wy6_q <= wy5_q;
  end

  // stage 7: vertical lerp product
  logic signed [24:0] dv;
  logic signed [49:0] pv_q;
  logic [FRAC_W-1:0]  h07_q;

  assign dv = $signed({1'b0, h1_q}) - $signed({1'b0, h0_q});

  always_ff @(posedge clk_i) begin
    pv_q  <= dv * $signed({1'b0, wy6_q});
    h07_q <= h0_q;
  end

  // stage 8: sample and billow fold
  logic signed [25:0] s_w;
  logic [SAMP_W-1:0]  s25, v2, dev, s8_q;

  assign s_w = $signed({2'b00, h07_q}) + 26'(pv_q >>> FRAC_W);
  assign s25 = SAMP_W'(s_w[FRAC_W-1:0]);
  assign v2  = s25 << 1;
  assign dev = (v2 >= ONE) ? (v2 - ONE) : (ONE - v2);

  always_ff @(posedge clk_i) begin
    s8_q <= cfg_i.billow_mode ? (ONE - dev) : s25;
  end

  // stage 9: amplitude weight
  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= enable_i ? PROD_W'(s8_q) *
              PROD_W'(cfg_i.billow_mode ? AMP_B : AMP_P) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[LANE_LAT-2:0], valid_i};
    end
  end

  assign valid_o = v_q[LANE_LAT-1];
  assign prod_o  = prod_q;

endmodule

// ----- rtl/pvnf_div.sv -----
// ----------------------------------------------------------------------------
// pvnf_div
// Rounded normalising divide, one quotient bit a stage, with saturation.
// ----------------------------------------------------------------------------
module pvnf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [pvnf_pkg::SUM_W-1:0]  sum_i,
  input  logic [pvnf_pkg::DEN_W-1:0]  den_i,
  output logic                        valid_o,
  output logic [pvnf_pkg::VAL_W-1:0]  value_o
);
  import pvnf_pkg::*;

  localparam int CW = SUM_W + 1;

  logic [SUM_W-1:0] rem_q  [QUO_W+1];
  logic [QUO_W-1:0] quo_q  [QUO_W+1];
  logic [DEN_W-1:0] den_q  [QUO_W+1];
  logic             zero_q [QUO_W+1];
  logic [QUO_W:0]   v_q;

  logic [VAL_W-1:0] val_q;
  logic             vo_q;

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= sum_i + SUM_W'(den_i >> 1);
    quo_q[0]  <= '0;
    den_q[0]  <= den_i;
    zero_q[0] <= (den_i == '0);
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_bit
    localparam int J = QUO_W - 1 - i;
    logic [CW-1:0] sub_w, rem_w;
    assign sub_w = CW'(den_q[i]) << J;
    assign rem_w = CW'(rem_q[i]);
    always_ff @(posedge clk_i) begin
      if (rem_w >= sub_w) begin
        rem_q[i+1] <= SUM_W'(rem_w - sub_w);
        quo_q[i+1] <= quo_q[i] | (QUO_W'(1) << J);
      end else begin
        rem_q[i+1] <= rem_q[i];
        quo_q[i+1] <= quo_q[i];
      end
      den_q[i+1]  <= den_q[i];
      zero_q[i+1] <= zero_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (zero_q[QUO_W]) begin
      val_q <= '0;
    end else if (quo_q[QUO_W][QUO_W-1:VAL_W] != '0) begin
      val_q <= '1;
    end else begin
      val_q <= quo_q[QUO_W][VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      vo_q <= 1'b0;
    end else begin
      v_q  <= {v_q[QUO_W-1:0], valid_i};
      vo_q <= v_q[QUO_W];
    end
  end

  assign valid_o = vo_q;
  assign value_o = val_q;

endmodule

// ----- rtl/periodic_value_noise_fbm.sv -----
// ----------------------------------------------------------------------------
// periodic_value_noise_fbm
// Fractal value noise, periodic in x, summed over up to MAX_OCTAVES octaves.
//
//   channel   signals                                   transfer
//   --------  ----------------------------------------  ----------------------
//   sample    start, busy, x_coord_i, y_coord_i          start && !busy
//   result    done_o, noise_value_o                      done_o (one cycle)
//   config    psel, penable, pwrite, paddr, pwdata,       psel&&penable&&pwrite
//             prdata, pready                              (pready always high)
//
// One sample per cycle. A sample passes the x wrap remainder, the octave lanes,
// the sum chain, then the divider.
// busy stays low; the receiver cannot stall, so there is no back pressure.
// Reset clears the valid chain and loads register defaults.
// ----------------------------------------------------------------------------
`include "periodic_value_noise_fbm_defines.svh"

module periodic_value_noise_fbm #(
  parameter int MAX_OCTAVES     = pvnf_pkg::DEF_MAX_OCTAVES,
  parameter int COORD_FRAC_BITS = pvnf_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [pvnf_pkg::COORD_W-1:0] x_coord_i,
  input  logic signed [pvnf_pkg::COORD_W-1:0] y_coord_i,
  output logic                                done_o,
  output logic [pvnf_pkg::VAL_W-1:0]          noise_value_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pvnf_pkg::ADDR_W-1:0]         paddr,
  input  logic [pvnf_pkg::DATA_W-1:0]         pwdata,
  output logic [pvnf_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);
  import pvnf_pkg::*;

  localparam int F   = COORD_FRAC_BITS;
  localparam int DW  = PERIOD_W + F;
  localparam int NIW = $clog2(MAX_OCTAVES + 1);
  localparam int LAT = (COORD_W - F + 2) + LANE_LAT + MAX_OCTAVES + DIV_LAT;

  cfg_t cfg;

  pvnf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign busy = 1'b0;

  // octave count clamp, norm table, lane enables
  logic [OCT_W-1:0]       n_clamp;
  logic [NORM_W-1:0]      norm_p [MAX_OCTAVES+1];
  logic [NORM_W-1:0]      norm_b [MAX_OCTAVES+1];
  logic [DEN_W-1:0]       den_q;
  logic [MAX_OCTAVES-1:0] lane_en;

  assign n_clamp = (cfg.octave_count > OCT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES)
                                                             : cfg.octave_count;

  for (genvar n = 0; n <= MAX_OCTAVES; n++) begin : g_norm
    assign norm_p[n] = octave_norm(n, 1'b0);
    assign norm_b[n] = octave_norm(n, 1'b1);
  end

  always_ff @(posedge clk_i) begin
    den_q <= DEN_W'(cfg.billow_mode ? norm_b[n_clamp[NIW-1:0]]
                                    : norm_p[n_clamp[NIW-1:0]]) << 8;
  end

  // x wrap
  logic                      wv;
  logic [DW-1:0]             wrem;
  logic signed [COORD_W-1:0] wy;

  pvnf_wrap #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_wrap (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (start && !busy),
    .x_i           (x_coord_i),
    .y_i           (y_coord_i),
    .base_period_i (cfg.base_period),
    .valid_o       (wv),
    .rem_o         (wrem),
    .y_o           (wy)
  );

  // octave lanes
  logic [MAX_OCTAVES-1:0] lane_v;
  logic [PROD_W-1:0]      prod [MAX_OCTAVES];

  for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
    assign lane_en[k] = (OCT_W'(k) < n_clamp);
    pvnf_octave #(
      .K               (k),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_octave (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (wv),
      .rem_i    (wrem),
      .y_i      (wy),
      .cfg_i    (cfg),
      .enable_i (lane_en[k]),
      .valid_o  (lane_v[k]),
      .prod_o   (prod[k])
    );
  end

  // sum chain, one octave term a stage
  logic [SUM_W-1:0]       acc_q  [MAX_OCTAVES];
  logic [PROD_W-1:0]      pipe_q [MAX_OCTAVES][MAX_OCTAVES];
  logic [MAX_OCTAVES-1:0] cv_q;

  for (genvar j = 0; j < MAX_OCTAVES; j++) begin : g_acc
    if (j == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        acc_q[j]  <= SUM_W'(prod[j]);
        pipe_q[j] <= prod;
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        acc_q[j]  <= acc_q[j-1] + SUM_W'(pipe_q[j-1][j]);
        pipe_q[j] <= pipe_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0;
    end else if (MAX_OCTAVES > 1) begin
      cv_q <= MAX_OCTAVES'({cv_q, &lane_v});
    end else begin
      cv_q <= MAX_OCTAVES'(&lane_v);
    end
  end

  pvnf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cv_q[MAX_OCTAVES-1]),
    .sum_i   (acc_q[MAX_OCTAVES-1]),
    .den_i   (den_q),
    .valid_o (done_o),
    .value_o (noise_value_o)
  );

  `PVNF_ASSERT_IMP(a_done_lat, done_o, $past(start && !busy, LAT))
  `PVNF_ASSERT_IMP(a_zero_oct, done_o && (cfg.octave_count == '0), noise_value_o == '0)
  `PVNF_ASSERT_IMP(a_lane_sync, lane_v[0], &lane_v)

endmodule
